// ===== hdl/ple_pkg.sv =====
package ple_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int DATA_W           = 32;
    localparam int POS_W            = 8;
    localparam int OUT_CNT_W        = 5;
    localparam int IN_DATA_W        = DATA_W + POS_W;
    localparam int OUT_DATA_W       = 72;

    localparam logic [DATA_W-1:0] NONE_VALUE = '1;

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_INSERT = 2'd2,
        FUNC_REMOVE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INSERT,
        SH_REMOVE
    } t_shift;

    // Per-cell control: which way the row moves and where this cell sits
    // relative to the chosen list position.
    typedef struct packed {
        t_shift op;
        logic   at_pos;
        logic   past_pos;
    } t_cell_ctl;

endpackage

// ===== hdl/ple_cell.sv =====
module ple_cell (
    input  logic                          i_clk,
    input  ple_pkg::t_cell_ctl            i_ctl,
    input  logic [ple_pkg::DATA_W-1:0]    i_value,
    input  logic [ple_pkg::DATA_W-1:0]    i_left,
    input  logic [ple_pkg::DATA_W-1:0]    i_right,
    output logic [ple_pkg::DATA_W-1:0]    o_data
);

    logic [ple_pkg::DATA_W-1:0] r_data;
    logic [ple_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            ple_pkg::SH_INSERT: begin
                if (i_ctl.at_pos) begin
                    n_data = i_value;
                end else if (i_ctl.past_pos) begin
                    n_data = i_left;
                end
            end
            ple_pkg::SH_REMOVE: begin
                if (i_ctl.at_pos || i_ctl.past_pos) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hdl/positional_list_engine.sv =====
// Channel   | Dir | Payload (lowest bit first)
// ----------+-----+-----------------------------------------------------------
// s_axis    | in  | tuser: func[1:0]; tdata: value[31:0], position[39:32]
// m_axis    | out | tdata: popped_value[31:0], front_value[63:32],
//           |     |        entry_count[68:64], is_empty[69], rejected[70], 0s
//
// For each item, the row of cells shifts all entries in parallel, and the result
// lands in the output register on the edge that accepts the item.
// Sustained rate is one item per cycle while the result side keeps taking.
// Reset (synchronous, active low) empties the list and drops any held result;
// entry contents are not cleared, only the count.
// A stalled result holds in the output register; input is taken again as soon
// as that register is free or being drained in the same cycle.
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::DEFAULT_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ple_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // value, position
    input  logic [1:0]                        s_axis_tuser,  // func
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ple_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // popped, front, count,
                                                             // is_empty, rejected
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W + 2 > ple_pkg::POS_W + 1) ? CNT_W + 2 : ple_pkg::POS_W + 1;
    localparam int PAD_W = ple_pkg::OUT_DATA_W - 2 * ple_pkg::DATA_W - ple_pkg::OUT_CNT_W - 2;

    // Input item fields
    ple_pkg::t_func                      w_func;
    logic [ple_pkg::DATA_W-1:0]          w_value;
    logic signed [ple_pkg::POS_W-1:0]    w_pos;

    assign w_func  = ple_pkg::t_func'(s_axis_tuser);
    assign w_value = s_axis_tdata[ple_pkg::DATA_W-1:0];
    assign w_pos   = s_axis_tdata[ple_pkg::IN_DATA_W-1:ple_pkg::DATA_W];

    // Control state and output register
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;
    logic                             r_m_valid;
    logic [ple_pkg::OUT_DATA_W-1:0]   r_m_data;
    logic [ple_pkg::OUT_DATA_W-1:0]   n_m_data;

    logic w_accept;
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Clamp the 1-based position into an index for insert and for remove
    logic signed [CMP_W-1:0] w_pos_ext;
    logic signed [CMP_W-1:0] w_len_ext;
    logic signed [CMP_W-1:0] w_ins_idx;
    logic signed [CMP_W-1:0] w_rem_idx;

    assign w_pos_ext = CMP_W'(w_pos);
    assign w_len_ext = $signed({{(CMP_W - CNT_W){1'b0}}, r_count});

    always_comb begin
        if (w_pos_ext < CMP_W'(1)) begin
            w_ins_idx = '0;
            w_rem_idx = '0;
        end else if (w_pos_ext > w_len_ext) begin
            w_ins_idx = w_len_ext;
            w_rem_idx = w_len_ext - CMP_W'(1);
        end else begin
            w_ins_idx = w_pos_ext - CMP_W'(1);
            w_rem_idx = w_pos_ext - CMP_W'(1);
        end
    end

    // Decode the operation: push and pop work at the front
    logic                 w_full;
    logic                 w_empty;
    logic                 w_ins_ok;
    logic                 w_rem_ok;
    logic                 w_rejected;
    logic                 w_is_pop;
    logic [IDX_W-1:0]     w_idx;

    assign w_full  = (r_count >= CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_ins_ok   = 1'b0;
        w_rem_ok   = 1'b0;
        w_rejected = 1'b0;
        w_is_pop   = 1'b0;
        w_idx      = '0;
        case (w_func)
            ple_pkg::FUNC_PUSH: begin
                w_ins_ok   = !w_full;
                w_rejected = w_full;
            end
            ple_pkg::FUNC_POP: begin
                w_rem_ok = !w_empty;
                w_is_pop = 1'b1;
            end
            ple_pkg::FUNC_INSERT: begin
                w_ins_ok   = !w_full;
                w_rejected = w_full;
                w_idx      = w_ins_idx[IDX_W-1:0];
            end
            ple_pkg::FUNC_REMOVE: begin
                w_rem_ok = !w_empty;
                w_idx    = w_rem_idx[IDX_W-1:0];
            end
            default: begin
                w_idx = '0;
            end
        endcase
    end

    // Row of cells: entry 0 is the front
    logic [ple_pkg::DATA_W-1:0] w_data [CAPACITY];
    ple_pkg::t_cell_ctl         w_ctl  [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ple_pkg::DATA_W-1:0] w_left;
        logic [ple_pkg::DATA_W-1:0] w_right;

        always_comb begin
            if (!w_accept) begin
                w_ctl[g].op = ple_pkg::SH_HOLD;
            end else if (w_ins_ok) begin
                w_ctl[g].op = ple_pkg::SH_INSERT;
            end else if (w_rem_ok) begin
                w_ctl[g].op = ple_pkg::SH_REMOVE;
            end else begin
                w_ctl[g].op = ple_pkg::SH_HOLD;
            end
            w_ctl[g].at_pos   = (w_idx == IDX_W'(g));
            w_ctl[g].past_pos = (IDX_W'(g) > w_idx);
        end

        // Front cell has no left neighbor, back cell no right one
        if (g == 0) begin : g_first
            assign w_left = w_value;
        end else begin : g_mid_left
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_right
            assign w_right = w_data[g+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

    // Result of this item
    logic [ple_pkg::DATA_W-1:0]  w_popped;
    logic [ple_pkg::DATA_W-1:0]  w_front;
    logic [CNT_W+4:0]            w_cnt_wide;

    always_comb begin
        n_count = r_count;
        if (w_ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_rem_ok) begin
            n_count = r_count - CNT_W'(1);
        end

        w_popped = (w_is_pop && w_rem_ok) ? w_data[0] : ple_pkg::NONE_VALUE;

        // Front after the shift, taken from the cells' neighbors
        if (n_count == '0) begin
            w_front = ple_pkg::NONE_VALUE;
        end else if (w_ins_ok && w_idx == '0) begin
            w_front = w_value;
        end else if (w_rem_ok && w_idx == '0) begin
            w_front = w_data[1];
        end else begin
            w_front = w_data[0];
        end

        w_cnt_wide = {5'b0, n_count};
        n_m_data   = {{PAD_W{1'b0}}, w_rejected, (n_count == '0),
                      w_cnt_wide[ple_pkg::OUT_CNT_W-1:0], w_front, w_popped};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= n_m_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
